FILE: hdl/dqrp_pkg.sv
// Shared types, constants and status codes for the DNS query/response pairing unit.
// Has no dependencies; every other file but dqrp_ram imports it.
package dqrp_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths.
    localparam int KEY_W   = 48;
    localparam int SEC_W   = 32;
    localparam int NSEC_W  = 30;
    localparam int SIZE_W  = 16;
    localparam int TTL_W   = 16;
    localparam int CNT_W   = 7;

    // Nanosecond constants.
    localparam logic [NSEC_W-1:0] NSEC_PER_SEC = 30'd1000000000;
    localparam logic [NSEC_W-1:0] NSEC_MAX     = 30'd999999999;

    // Register reset value.
    localparam logic [TTL_W-1:0] TTL_RESET = 16'd5;

    // Request codes.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_PURGE = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_MATCHED   = 3'd2;
    localparam logic [2:0] ST_TIMED_OUT = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_PURGED    = 3'd5;

    // Input word.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [31:0]       flow_key;
        logic [15:0]       query_id;
        logic [SEC_W-1:0]  stamp_sec;
        logic [NSEC_W-1:0] stamp_nsec;
        logic [SIZE_W-1:0] query_size;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [2:0]        status;
        logic [SEC_W-1:0]  latency_sec;
        logic [NSEC_W-1:0] latency_nsec;
        logic [SIZE_W-1:0] matched_size;
        logic [CNT_W-1:0]  purged_count;
    } t_out_word;

    // One stored table entry as held in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
        logic [SIZE_W-1:0] size;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic calc;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/dqrp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module dqrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/dqrp_ctrl.sv
// Sequencing state machine of the pairing unit: accept, scan, drain, calculate, emit.
// Depends on dqrp_pkg for the command and status structs.
module dqrp_ctrl import dqrp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_CALC,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/dqrp_dp.sv
// Datapath of the pairing unit: item registers, valid bits, entry memory scan,
// latency arithmetic, TTL register and output word register.
// Depends on dqrp_pkg and dqrp_ram.
module dqrp_dp import dqrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_word         i_in_word,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_cfg_we,
    input  logic [TTL_W-1:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word
);

    // Current item.
    logic [1:0]        r_req;
    logic [KEY_W-1:0]  r_key;
    logic [SEC_W-1:0]  r_sec;
    logic [NSEC_W-1:0] r_nsec;
    logic [SIZE_W-1:0] r_size;

    logic [TTL_W-1:0]   r_ttl;
    logic [ENTRIES-1:0] r_valid;

    // Scan pointer and compare stage.
    logic [IDX_W-1:0] r_cnt;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;

    // Scan results.
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;
    logic [SEC_W-1:0]  r_q_sec;
    logic [NSEC_W-1:0] r_q_nsec;
    logic [SIZE_W-1:0] r_q_size;
    logic [CNT_W-1:0]  r_pcount;

    // Raw differences.
    logic [NSEC_W:0]  r_dnsec;
    logic [SEC_W:0]   r_dsec;

    logic      r_out_vld;
    t_out_word r_out;

    logic [ENT_W-1:0] w_rdata;
    t_entry           w_ent;
    t_entry           w_wr_ent;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_cur_valid;
    logic             w_key_eq;
    logic             w_aged;
    logic             w_scan_last;
    logic [NSEC_W:0]  w_nsec_adj;
    logic [SEC_W:0]   w_sec_adj;
    logic             w_borrow;
    logic [SEC_W:0]   w_sec_fix;
    logic [NSEC_W:0]  w_nsec_fix;
    logic [SEC_W-1:0] w_lsec;
    logic [NSEC_W-1:0] w_lnsec;
    t_out_word        w_res;

    // Entry memory: key, query time and size of every slot.
    dqrp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr_ent),
        .i_raddr (r_cnt),
        .o_rdata (w_rdata)
    );

    assign w_ent = t_entry'(w_rdata);

    // Compare stage: data of slot r_cmp_idx arrives from the memory now.
    assign w_cur_valid = r_valid[r_cmp_idx];
    assign w_key_eq    = (w_ent.key == r_key);
    assign w_aged      = ({1'b0, r_sec} >= ({1'b0, w_ent.sec} + {{(SEC_W+1-TTL_W){1'b0}}, r_ttl}));

    // A start item writes its slot during the calculate step.
    assign w_wr_ent = '{key: r_key, sec: r_sec, nsec: r_nsec, size: r_size};
    assign w_we     = i_cmd.calc && (r_req == REQ_START) && (r_hit || r_free_found);
    assign w_waddr  = r_hit ? r_hit_idx : r_free_idx;

    assign w_scan_last = (r_cnt == IDX_W'(ENTRIES - 1));
    assign o_stat      = '{scan_last: w_scan_last, out_free: (!r_out_vld || i_out_ready)};

    // Item registers, scan pointer and scan results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in_word.req_type;
            r_key  <= {i_in_word.flow_key, i_in_word.query_id};
            r_sec  <= i_in_word.stamp_sec;
            r_nsec <= (i_in_word.stamp_nsec > NSEC_MAX) ? NSEC_MAX : i_in_word.stamp_nsec;
            r_size <= i_in_word.query_size;
            r_cnt  <= '0;
        end else if (i_cmd.scan && !w_scan_last) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_cmp_idx <= r_cnt;

        if (i_cmd.load) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_pcount     <= '0;
        end else if (r_cmp_vld) begin
            // The key is unique in the table, so at most one slot matches.
            if (w_cur_valid && w_key_eq) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_q_sec   <= w_ent.sec;
                r_q_nsec  <= w_ent.nsec;
                r_q_size  <= w_ent.size;
            end
            // Keep the lowest free slot.
            if (!w_cur_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
            if ((r_req == REQ_PURGE) && w_cur_valid && w_aged && (r_pcount != '1)) begin
                r_pcount <= r_pcount + 1'b1;
            end
        end

        if (i_cmd.calc) begin
            r_dnsec <= {1'b0, r_nsec} - {1'b0, r_q_nsec};
            r_dsec  <= {1'b0, r_sec} - {1'b0, r_q_sec};
        end
    end

    // Control registers: compare strobe, valid bits, TTL and output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_ttl     <= TTL_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cfg_we) begin
                r_ttl <= i_cfg_wdata;
            end
            // Purge clears aged slots as the scan passes them.
            if (r_cmp_vld && (r_req == REQ_PURGE) && w_cur_valid && w_aged) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cmd.calc && (r_req == REQ_END) && r_hit) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Latency: borrow a second when the nanosecond difference is negative,
    // then saturate a negative latency to zero.
    assign w_borrow   = r_dnsec[NSEC_W];
    assign w_nsec_adj = r_dnsec + {1'b0, NSEC_PER_SEC};
    assign w_sec_adj  = r_dsec - 1'b1;
    assign w_sec_fix  = w_borrow ? w_sec_adj : r_dsec;
    assign w_nsec_fix = w_borrow ? w_nsec_adj : r_dnsec;
    assign w_lsec     = w_sec_fix[SEC_W] ? '0 : w_sec_fix[SEC_W-1:0];
    assign w_lnsec    = w_sec_fix[SEC_W] ? '0 : w_nsec_fix[NSEC_W-1:0];

    // Result word by request type.
    always_comb begin
        w_res        = '0;
        w_res.status = ST_NOT_FOUND;
        case (r_req)
            REQ_START: begin
                w_res.status = (r_hit || r_free_found) ? ST_STORED : ST_FULL;
            end
            REQ_END: begin
                if (r_hit) begin
                    w_res.latency_sec  = w_lsec;
                    w_res.latency_nsec = w_lnsec;
                    w_res.matched_size = r_q_size;
                    w_res.status = (w_lsec >= {{(SEC_W-TTL_W){1'b0}}, r_ttl}) ?
                                   ST_TIMED_OUT : ST_MATCHED;
                end
            end
            REQ_PURGE: begin
                w_res.status       = ST_PURGED;
                w_res.purged_count = r_pcount;
            end
            default: begin
                w_res.status = ST_NOT_FOUND;
            end
        endcase
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

FILE: hdl/dns_query_response_pairing_unit.sv
// Top level of the DNS query/response pairing unit.
// Depends on dqrp_pkg, dqrp_ctrl, dqrp_dp and dqrp_ram.
//
// Usage:
//   Input words (start, response, purge) arrive on i_in_valid / o_in_ready and
//   are accepted when both are high. Each word gives exactly one result word
//   on o_out_valid / i_out_ready, held stable until taken.
//   The TTL register is written through i_cfg_we / i_cfg_wdata; the user
//   must write it only while the unit is idle, which the unit does not enforce.
//   Every word scans all ENTRIES slots of the entry memory through its single
//   read port, one slot per cycle, then passes the drain and calculate steps
//   and registers its result in the emit step. One word is in flight at a time.
//   The output register frees the input side: a new word is accepted while
//   the previous result still waits. If the receiver stalls, the next result
//   waits in the final step until the output register is free.
//   Synchronous reset clears all slot valid bits at once, sets the TTL to 5
//   seconds and empties the output register; no clearing pass is needed.
module dns_query_response_pairing_unit import dqrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [TTL_W-1:0] i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    dqrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // Table, arithmetic and output register.
    dqrp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // An accepted word is followed by a busy period.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // A fresh result appears only as the sequencer returns to idle.
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result registered while a word is still in progress");

    // Only purge results carry a count.
    a_count_only_purge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != ST_PURGED)) |-> (o_out_word.purged_count == '0))
        else $error("purge count on a non-purge result");

    // Only matched and timed-out results carry a size.
    a_size_only_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != ST_MATCHED)
            && (o_out_word.status != ST_TIMED_OUT)) |-> (o_out_word.matched_size == '0))
        else $error("matched size on an unmatched result");

endmodule

FILE: tb/dns_query_response_pairing_unit_tb.sv
// Self-checking testbench for the DNS query/response pairing unit.
// A local model of the pairing table predicts every result word; it depends only on dqrp_pkg
// and the unit itself.
`timescale 1ns / 1ps

module dns_query_response_pairing_unit_tb;
    import dqrp_pkg::*;

    // Request code that the unit does not define; it must leave the table alone.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [NSEC_W-1:0] NSEC_FIELD_MAX = '1;
    localparam int unsigned RUN_LIMIT_NS = 4_000_000;
    localparam int KEY_POOL = 48;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_word         in_word = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_word        out_word;
    logic             cfg_we = 1'b0;
    logic [TTL_W-1:0] cfg_wdata = '0;

    // Local copy of the table and of the TTL register.
    bit                tab_valid [ENTRIES];
    logic [KEY_W-1:0]  tab_key [ENTRIES];
    logic [SEC_W-1:0]  tab_sec [ENTRIES];
    logic [NSEC_W-1:0] tab_nsec [ENTRIES];
    logic [SIZE_W-1:0] tab_size [ENTRIES];
    logic [TTL_W-1:0]  ttl_cfg = TTL_RESET;

    t_in_word  words_to_send [$];
    t_out_word expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int words_accepted = 0;
    int mismatches = 0;
    int status_tally [8];

    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [SEC_W-1:0] clock_sec;

    dns_query_response_pairing_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [NSEC_W-1:0] clamp_nsec(logic [NSEC_W-1:0] v);
        return (v > NSEC_MAX) ? NSEC_MAX : v;
    endfunction

    function automatic int find_entry(logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tab_valid[i] && tab_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one word to the local table and returns the result word it should give.
    function automatic t_out_word table_outcome(t_in_word w);
        logic [KEY_W-1:0]  key;
        logic [NSEC_W-1:0] snsec;
        t_out_word         r;
        int                slot;
        int                n;
        longint            dsec;
        longint            dnsec;
        key   = {w.flow_key, w.query_id};
        snsec = clamp_nsec(w.stamp_nsec);
        r = '0;
        r.status = ST_NOT_FOUND;
        case (w.req_type)
            REQ_START: begin
                slot = find_entry(key);
                if (slot < 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!tab_valid[i]) begin
                            slot = i;
                            break;
                        end
                    end
                end
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    tab_valid[slot] = 1'b1;
                    tab_key[slot]   = key;
                    tab_sec[slot]   = w.stamp_sec;
                    tab_nsec[slot]  = snsec;
                    tab_size[slot]  = w.query_size;
                    r.status = ST_STORED;
                end
            end
            REQ_END: begin
                slot = find_entry(key);
                if (slot >= 0) begin
                    dsec  = longint'(w.stamp_sec) - longint'(tab_sec[slot]);
                    dnsec = longint'(snsec) - longint'(clamp_nsec(tab_nsec[slot]));
                    // Borrow one second when the nanosecond part goes negative.
                    if (dnsec < 0) begin
                        dsec  = dsec - 1;
                        dnsec = dnsec + longint'(NSEC_PER_SEC);
                    end
                    // A response earlier than its query reads as zero latency.
                    if (dsec < 0) begin
                        dsec  = 0;
                        dnsec = 0;
                    end
                    r.latency_sec  = dsec[SEC_W-1:0];
                    r.latency_nsec = dnsec[NSEC_W-1:0];
                    r.matched_size = tab_size[slot];
                    r.status = (dsec >= longint'(ttl_cfg)) ? ST_TIMED_OUT : ST_MATCHED;
                    tab_valid[slot] = 1'b0;
                end
            end
            REQ_PURGE: begin
                n = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tab_valid[i] &&
                        longint'(w.stamp_sec) >= longint'(ttl_cfg) + longint'(tab_sec[i])) begin
                        tab_valid[i] = 1'b0;
                        if (n < 127) begin
                            n++;
                        end
                    end
                end
                r.purged_count = n[CNT_W-1:0];
                r.status = ST_PURGED;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_in_word make_word(logic [1:0] req, logic [31:0] flow, logic [15:0] id,
                                           logic [31:0] sec, logic [29:0] nsec,
                                           logic [15:0] size);
        t_in_word w;
        w.req_type   = req;
        w.flow_key   = flow;
        w.query_id   = id;
        w.stamp_sec  = sec;
        w.stamp_nsec = nsec;
        w.query_size = size;
        return w;
    endfunction

    // Mostly legal nanoseconds, with some above the one-second limit.
    function automatic logic [NSEC_W-1:0] pick_nsec();
        if ($urandom_range(9) == 0) begin
            return NSEC_W'($urandom_range(32'(NSEC_FIELD_MAX), 32'(NSEC_MAX) + 1));
        end
        return NSEC_W'($urandom_range(32'(NSEC_MAX)));
    endfunction

    // Appends one word to the tail of the send queue.
    task automatic queue_word(t_in_word w);
        words_to_send.insert(words_to_send.size(), w);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Waits until no word is queued, offered or outstanding, then for an extra margin set by its argument.
    task automatic settle(int extra);
        @(negedge clk);
        while (words_to_send.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_ttl(logic [TTL_W-1:0] value);
        settle(8);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        ttl_cfg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random traffic: mostly starts and responses on a small key pool so that
    // pairs match, with purges, late and early responses and noise words.
    task automatic queue_traffic(int count);
        int               r;
        logic [KEY_W-1:0] k;
        logic [31:0]      sec;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            k = key_pool[$urandom_range(KEY_POOL - 1)];
            if ($urandom_range(99) < 4) begin
                clock_sec = clock_sec + 70000;
            end else begin
                clock_sec = clock_sec + $urandom_range(3);
            end
            sec = clock_sec;
            if (r < 40) begin
                queue_word(make_word(REQ_START, k[47:16], k[15:0], sec,
                                     pick_nsec(), 16'($urandom)));
            end else if (r < 80) begin
                if ($urandom_range(19) == 0) begin
                    sec = clock_sec - $urandom_range(10, 1);
                end
                queue_word(make_word(REQ_END, k[47:16], k[15:0], sec,
                                     pick_nsec(), 16'($urandom)));
            end else if (r < 88) begin
                queue_word(make_word(REQ_PURGE, $urandom, 16'($urandom), sec,
                                     pick_nsec(), 16'($urandom)));
            end else begin
                queue_word(make_word(2'($urandom_range(3)), $urandom, 16'($urandom),
                                     $urandom, 30'($urandom), 16'($urandom)));
            end
        end
    endtask

    // Sender: offers queued words and predicts each one as it is accepted.
    always @(posedge clk) begin : drive_words
        t_out_word predicted;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predicted = table_outcome(in_word);
                expected_results.insert(expected_results.size(), predicted);
                words_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word  <= words_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with random idling and an occasional long hold-off.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: each taken result word against the oldest prediction.
    always @(posedge clk) begin : take_result
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            status_tally[out_word.status]++;
            if (expected_results.size() == 0) begin
                $error("result word with none outstanding: status %0d", out_word.status);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(out_word.status));
                check_field("latency_sec", want.latency_sec, out_word.latency_sec);
                check_field("latency_nsec", 32'(want.latency_nsec),
                            32'(out_word.latency_nsec));
                check_field("matched_size", 32'(want.matched_size),
                            32'(out_word.matched_size));
                check_field("purged_count", 32'(want.purged_count),
                            32'(out_word.purged_count));
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = {$urandom, 16'($urandom)};
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 83;

        // Directed words with the TTL at its reset value of five seconds.
        queue_word(make_word(REQ_PURGE, 0, 0, 0, 0, 0));
        queue_word(make_word(REQ_START, 0, 0, 100, 0, 0));
        queue_word(make_word(REQ_START, 32'hFFFF_FFFF, 16'hFFFF, 100,
                             NSEC_MAX, 16'hFFFF));
        // Duplicate start overwrites the first entry in place.
        queue_word(make_word(REQ_START, 0, 0, 200, 500, 1234));
        // Response with a nanosecond borrow.
        queue_word(make_word(REQ_END, 0, 0, 203, 400, 0));
        queue_word(make_word(REQ_END, 0, 0, 203, 400, 0));
        // Latency exactly at the TTL counts as timed out.
        queue_word(make_word(REQ_END, 32'hFFFF_FFFF, 16'hFFFF, 105,
                             NSEC_MAX, 0));
        // Out-of-range nanoseconds, then a response earlier than its query.
        queue_word(make_word(REQ_START, 32'h1234_5678, 16'h0001, 50,
                             NSEC_FIELD_MAX, 7));
        queue_word(make_word(REQ_END, 32'h1234_5678, 16'h0001, 40, 0, 0));
        queue_word(make_word(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF,
                             32'hFFFF_FFFF, NSEC_FIELD_MAX, 16'hFFFF));
        // Purge compare must not wrap for a query at the top of the seconds range.
        queue_word(make_word(REQ_START, 32'h0000_0002, 16'h0002,
                             32'hFFFF_FFFF, 0, 2));
        queue_word(make_word(REQ_START, 32'h0000_0003, 16'h0003, 10, 0, 3));
        queue_word(make_word(REQ_PURGE, 0, 0, 32'hFFFF_FFFF, 0, 0));
        queue_word(make_word(REQ_END, 32'h0000_0002, 16'h0002,
                             32'hFFFF_FFFF, NSEC_FIELD_MAX, 0));
        queue_word(make_word(REQ_START, 32'h0000_0004, 16'h0004, 0, 0, 4));
        queue_word(make_word(REQ_END, 32'h0000_0004, 16'h0004, 0, 0, 0));

        // TTL of zero: even a negative latency counts as timed out.
        write_ttl('0);
        queue_word(make_word(REQ_START, 32'h1234_5678, 16'h0005, 5, 10, 5));
        queue_word(make_word(REQ_END, 32'h1234_5678, 16'h0005, 4, 20, 0));
        queue_word(make_word(REQ_START, 32'h1234_5678, 16'h0006, 1000, 0, 6));
        queue_word(make_word(REQ_PURGE, 0, 0, 1000, 0, 0));

        // Largest TTL: one second below and exactly at it.
        write_ttl(16'hFFFF);
        queue_word(make_word(REQ_START, 32'h0000_0007, 16'h0007, 0, 0, 1));
        queue_word(make_word(REQ_END, 32'h0000_0007, 16'h0007, 65534,
                             NSEC_MAX, 0));
        queue_word(make_word(REQ_START, 32'h0000_0008, 16'h0008, 10, 5, 8));
        queue_word(make_word(REQ_END, 32'h0000_0008, 16'h0008, 65545, 5, 0));

        // Random phase one: sender idles little, receiver idles much.
        write_ttl(16'd3);
        clock_sec = $urandom;
        queue_traffic(200);

        // Random phase two: the other way round.
        write_ttl(16'($urandom_range(20)));
        send_idle_pct = 83;
        recv_idle_pct = 16;
        clock_sec = $urandom;
        queue_traffic(200);

        // Random phase three: no idling, a long receiver hold-off at the start,
        // and a flood of fresh keys that overflows the table before a purge clears it.
        write_ttl(16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1200;
        clock_sec = $urandom;
        queue_traffic(60);
        for (int i = 0; i < ENTRIES + 6; i++) begin
            queue_word(make_word(REQ_START, $urandom, 16'($urandom), clock_sec,
                                 pick_nsec(), 16'($urandom)));
        end
        clock_sec = clock_sec + 100000;
        queue_word(make_word(REQ_PURGE, 0, 0, clock_sec, 0, 0));
        queue_traffic(70);

        settle(80);
        $display("%0d words checked: %0d stored, %0d table full, %0d matched, %0d timed out,",
                 words_accepted, status_tally[ST_STORED], status_tally[ST_FULL],
                 status_tally[ST_MATCHED], status_tally[ST_TIMED_OUT]);
        $display("%0d not found, %0d purges; TTL of 5, 0, 65535 and random values",
                 status_tally[ST_NOT_FOUND], status_tally[ST_PURGED]);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
